// ===== rtl/ukf_pkg.sv =====
package ukf_pkg;

   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int OCC_W      = 5;
   localparam int ENTRY_W    = KEY_W + DATA_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      status_type                status;
      logic signed [KEY_W-1:0]   out_key;
      logic signed [DATA_W-1:0]  out_payload;
      logic [OCC_W-1:0]          occupancy;
      logic                      is_empty;
   } rsp_type;

endpackage

// ===== rtl/ukf_ram.sv =====
module ukf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ukf_ctrl.sv =====
module ukf_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ukf_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ukf_pkg::KEY_W-1:0]     req_key,
   input  logic [ukf_pkg::DATA_W-1:0]    req_payload,
   output logic                          req_ready,
   input  logic                          out_free,
   output logic                          rsp_load,
   output ukf_pkg::rsp_type              rsp,
   output logic                          ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]      ram_wr_addr,
   output logic [ukf_pkg::ENTRY_W-1:0]   ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]      ram_rd_addr,
   input  logic [ukf_pkg::ENTRY_W-1:0]   ram_rd_data
);

   import ukf_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]  payload_ff, payload_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               dup_ff, dup_in;

   logic               issue;
   logic               key_match;
   logic [CNT_W-1:0]   new_count;

   assign req_ready   = (state_ff == S_IDLE);
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_ptr_ff : head_ff;
   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = {payload_ff, key_ff};
   assign key_match   = (ram_rd_data[KEY_W-1:0] == key_ff);
   assign issue       = (issue_cnt_ff != count_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      payload_in   = payload_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_pend_in   = rd_pend_ff;
      dup_in       = dup_ff;
      new_count    = count_ff;
      rsp_load     = 1'b0;
      ram_wr_en    = 1'b0;
      rsp.status      = ST_OK;
      rsp.out_key     = '0;
      rsp.out_payload = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_cmd;
               key_in       = req_key;
               payload_in   = req_payload;
               dup_in       = 1'b0;
               scan_ptr_in  = head_ff;
               issue_cnt_in = '0;
               rd_pend_in   = 1'b0;
               if (req_cmd == CMD_ENQ && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            // one slot read per cycle from head; the compare lands in the following cycle
            if (issue) begin
               scan_ptr_in  = (scan_ptr_ff == LAST_SLOT) ? '0 : scan_ptr_ff + 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            rd_pend_in = issue;
            if (rd_pend_ff && key_match) begin
               dup_in = 1'b1;
            end
            if (!issue && !rd_pend_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            case (cmd_ff)
               CMD_ENQ: begin
                  if (count_ff != '0 && dup_ff) begin
                     rsp.status = ST_DUP;
                  end else if (count_ff >= FULL_CNT) begin
                     rsp.status = ST_FULL;
                  end else begin
                     new_count = count_ff + 1'b1;
                  end
               end
               CMD_DEQ, CMD_PEEK: begin
                  if (count_ff == '0) begin
                     rsp.status = ST_EMPTY;
                  end else begin
                     // head slot was addressed the whole time, read data is current
                     rsp.out_key     = ram_rd_data[KEY_W-1:0];
                     rsp.out_payload = ram_rd_data[ENTRY_W-1:KEY_W];
                     if (cmd_ff == CMD_DEQ) begin
                        new_count = count_ff - 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               count_in = new_count;
               if (cmd_ff == CMD_ENQ && rsp.status == ST_OK) begin
                  ram_wr_en = 1'b1;
                  tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
               end
               if (cmd_ff == CMD_DEQ && rsp.status == ST_OK) begin
                  head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp.occupancy = OCC_W'(new_count);
      rsp.is_empty  = (new_count == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         scan_ptr_ff  <= '0;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         dup_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         scan_ptr_ff  <= scan_ptr_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         dup_ff       <= dup_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) == (head_ff == tail_ff))
      else $error("head/tail pointers disagree with entry count");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> count_ff < FULL_CNT)
      else $error("write into a full queue");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> issue_cnt_ff <= count_ff)
      else $error("key scan ran past the held entries");
`endif

endmodule

// ===== rtl/unique_key_fifo_core.sv =====
// Queue of (key, payload) entries that refuses an enqueue whose key is already held.
// Dequeue, peek, unused commands and enqueue into an empty queue go straight to the result
// state; enqueue into a queue of n entries first scans all n held keys, one slot a cycle
// through the RAM read port. The result is registered and waits while the output stalls.
// One item at a time: the next item is taken only after the last result has been loaded.
// Reset (synchronous, active high) empties the queue; RAM contents are not cleared.
module unique_key_fifo_core #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ukf_pkg::REQ_DATA_W-1:0]    req_tdata,  // key[31:0], payload[63:32]
   input  logic [ukf_pkg::CMD_W-1:0]         req_tuser,  // cmd[1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ukf_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // out_key[31:0], out_payload[63:32],
                                                         // occupancy[68:64], is_empty[69], zero
   output logic [1:0]                        rsp_tuser   // status[1:0]
);

   import ukf_pkg::*;

   localparam int AW = $clog2(DEPTH);

   rsp_type             rsp_next;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_load;
   logic                out_free;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   ukf_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_cmd     (req_tuser),
      .req_key     (req_tdata[KEY_W-1:0]),
      .req_payload (req_tdata[KEY_W+DATA_W-1:KEY_W]),
      .req_ready   (req_tready),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp         (rsp_next),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ukf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.is_empty, rsp_ff.occupancy,
                        rsp_ff.out_payload, rsp_ff.out_key};

endmodule

// ===== tb/unique_key_fifo_core_test.sv =====
`timescale 1ns / 1ps

module unique_key_fifo_core_test;
   import ukf_pkg::*;

   localparam int QDEPTH        = 16;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int CALM_ITEMS    = 200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] payload;
      logic              typed;
      rsp_type           want;
   } step_row_type;

   localparam rsp_type UNCHECKED = '0;
   localparam rsp_type EMPTY_RSP = '{ST_EMPTY, 32'sh0, 32'sh0, 5'd0, 1'b1};

   localparam int PLAN_LEN = 22;
   localparam step_row_type PLAN [PLAN_LEN] = '{
      '{CMD_DEQ,    32'h0, 32'h0, 1'b1, EMPTY_RSP},
      '{CMD_PEEK,   32'h0, 32'h0, 1'b1, EMPTY_RSP},
      '{CMD_UNUSED, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'sh0, 32'sh0, 5'd0, 1'b1}},
      '{CMD_ENQ, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{ST_OK, 32'sh0, 32'sh0, 5'd1, 1'b0}},
      '{CMD_ENQ, 32'h8000_0000, 32'h0, 1'b1, '{ST_DUP, 32'sh0, 32'sh0, 5'd1, 1'b0}},
      '{CMD_PEEK, 32'h0, 32'h0, 1'b1,
        '{ST_OK, 32'sh8000_0000, 32'sh7fff_ffff, 5'd1, 1'b0}},
      '{CMD_ENQ,    32'h7fff_ffff, 32'h8000_0000, 1'b0, UNCHECKED},
      '{CMD_ENQ,    32'h0000_0000, 32'hffff_ffff, 1'b0, UNCHECKED},
      '{CMD_ENQ,    32'hffff_ffff, 32'h0000_0000, 1'b0, UNCHECKED},
      // duplicate of an entry that is not at the head
      '{CMD_ENQ,    32'h0000_0000, 32'h0000_0001, 1'b0, UNCHECKED},
      '{CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_PEEK,   32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      // keys still sitting in freed slots must not count as held
      '{CMD_ENQ,    32'h7fff_ffff, 32'haaaa_aaaa, 1'b0, UNCHECKED},
      '{CMD_ENQ,    32'h0000_0000, 32'h5555_5555, 1'b0, UNCHECKED},
      '{CMD_ENQ,    32'h5555_aaaa, 32'hffff_ffff, 1'b0, UNCHECKED},
      '{CMD_DEQ,    32'h0, 32'h0, 1'b0, UNCHECKED},
      '{CMD_PEEK,   32'h0, 32'h0, 1'b0, UNCHECKED}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // shadow of the queue
   logic [KEY_W-1:0]  key_slot [QDEPTH];
   logic [DATA_W-1:0] payload_slot [QDEPTH];
   bit                slot_used [QDEPTH];
   int                head_ptr = 0;
   int                tail_ptr = 0;
   int                fill_count = 0;

   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   int      cmd_count = 0;
   int      status_seen [4] = '{0, 0, 0, 0};
   int      send_odds = 0;
   int      stall_odds = 0;
   int      cycle_count = 0;

   unique_key_fifo_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type apply_queue_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                               logic [DATA_W-1:0] d);
      rsp_type r;
      bit      held;
      r = '0;
      r.status = ST_OK;
      held = 1'b0;
      case (cmd)
         CMD_ENQ: begin
            for (int i = 0; i < QDEPTH; i++)
               if (slot_used[i] && key_slot[i] == k) held = 1'b1;
            if (fill_count != 0 && held) begin
               r.status = ST_DUP;
            end else if (fill_count >= QDEPTH) begin
               r.status = ST_FULL;
            end else begin
               key_slot[tail_ptr]     = k;
               payload_slot[tail_ptr] = d;
               slot_used[tail_ptr]    = 1'b1;
               tail_ptr   = (tail_ptr + 1) % QDEPTH;
               fill_count = fill_count + 1;
            end
         end
         CMD_DEQ, CMD_PEEK: begin
            if (fill_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.out_key     = key_slot[head_ptr];
               r.out_payload = payload_slot[head_ptr];
               if (cmd == CMD_DEQ) begin
                  slot_used[head_ptr] = 1'b0;
                  head_ptr   = (head_ptr + 1) % QDEPTH;
                  fill_count = fill_count - 1;
               end
            end
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(fill_count);
      r.is_empty  = (fill_count == 0);
      return r;
   endfunction

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                        input logic [DATA_W-1:0] d, input logic typed, input rsp_type want);
      rsp_type model_rsp;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {d, k};
      do @(posedge clock); while (!req_tready);
      model_rsp = apply_queue_cmd(cmd, k, d);
      expected_rsps.push_back(typed ? want : model_rsp);
      cmd_count++;
   endtask

   task automatic idle_req(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch on %s at result %0d: expected %h, got %h",
                     field, rsp_count, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: status %0d, tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            status_seen[want.status]++;
            check_field("status", want.status, rsp_tuser);
            check_field("out_key", want.out_key, rsp_tdata[31:0]);
            check_field("out_payload", want.out_payload, rsp_tdata[63:32]);
            check_field("occupancy", want.occupancy, rsp_tdata[68:64]);
            check_field("is_empty", want.is_empty, rsp_tdata[69]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsps.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            stall_left = $urandom_range(1, 19);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      burst_mode_type   mode;
      int               burst_left;
      int               burst_num;
      int               counted;
      int               roll;
      int               enq_pct;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] k;
      logic [DATA_W-1:0] d;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_odds  = 4;
      stall_odds = 4;
      foreach (PLAN[i])
         issue(PLAN[i].cmd, PLAN[i].key, PLAN[i].payload, PLAN[i].typed, PLAN[i].want);
      wait_drained();

      counted    = 0;
      burst_left = 0;
      burst_num  = 0;
      mode       = MODE_MIX;
      while (counted < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(20, 80);
            burst_num++;
            mode = burst_mode_type'($urandom_range(0, 2));
            if (counted >= RANDOM_ITEMS - CALM_ITEMS) begin
               send_odds  = 0;
               stall_odds = 0;
            end else begin
               send_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
               stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
            end
            // hold the sender until the queue has answered everything
            if (burst_num % 6 == 3) wait_drained();
         end

         case (mode)
            MODE_FILL:  enq_pct = 75;
            MODE_DRAIN: enq_pct = 15;
            default:    enq_pct = 45;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 3)                 cmd = CMD_UNUSED;
         else if (roll < 3 + enq_pct)  cmd = CMD_ENQ;
         else if ($urandom_range(0, 3) == 0) cmd = CMD_PEEK;
         else                          cmd = CMD_DEQ;

         d = $urandom();
         if ($urandom_range(0, 19) == 0)
            d = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         roll = $urandom_range(0, 99);
         if (fill_count != 0 && roll < 15)
            k = key_slot[(head_ptr + $urandom_range(0, fill_count - 1)) % QDEPTH];
         else if (roll < 35)
            k = $urandom_range(0, 23);
         else
            k = $urandom();

         if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
            idle_req($urandom_range(1, 19));
         issue(cmd, k, d, 1'b0, UNCHECKED);
         if (cmd != CMD_UNUSED) counted++;
         burst_left--;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Issued %0d queue commands (%0d random), checked %0d results in %0d cycles",
               cmd_count, counted, rsp_count, cycle_count);
      $display("Status mix: ok %0d, duplicate %0d, full %0d, empty %0d",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
               status_seen[ST_EMPTY]);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
